@@ rtl/core/frame_receiver_sum_checksum_unit_macros.svh @@
// ----------------------------------------------------------------------------
// frame receiver assertion macros
// shared concurrent assertion forms for the frame receiver core
// ----------------------------------------------------------------------------
`ifndef FRAME_RECEIVER_SUM_CHECKSUM_UNIT_MACROS_SVH
`define FRAME_RECEIVER_SUM_CHECKSUM_UNIT_MACROS_SVH

// same-cycle implication, reset masks the check
`define FRSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset masks the check
`define FRSC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/frsc_pkg.sv @@
// ----------------------------------------------------------------------------
// frsc_pkg
// types and constants shared by the frame receiver core
// ----------------------------------------------------------------------------
package frsc_pkg;

  localparam logic [7:0]  START_BYTE      = 8'hAA;
  localparam logic [16:0] HEADER_LEN      = 17'd4;
  localparam logic [15:0] MAX_PAYLOAD_RST = 16'd256;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_START = 2'd1,
    STATUS_TOO_LONG  = 2'd2,
    STATUS_BAD_CSUM  = 2'd3
  } status_e;

  // one result beat
  typedef struct packed {
    logic [7:0]  byte_out;
    logic        frame_end;
    status_e     frame_status;
    logic [16:0] frame_total;
  } res_t;

endpackage

@@ rtl/core/frsc_parser.sv @@
// ----------------------------------------------------------------------------
// frsc_parser
// input register, frame state and per-byte status logic
// ----------------------------------------------------------------------------
`include "frame_receiver_sum_checksum_unit_macros.svh"

module frsc_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         rx_byte_i,
  input  logic [15:0]        max_payload_i,
  output logic               res_valid_o,
  input  logic               res_take_i,
  output frsc_pkg::res_t     res_o
);

  // header byte positions
  localparam logic [1:0] HDR_START  = 2'd0;
  localparam logic [1:0] HDR_LEN_HI = 2'd1;
  localparam logic [1:0] HDR_LEN_LO = 2'd2;
  localparam logic [1:0] HDR_OPCODE = 2'd3;

  logic        s1_valid_q, s1_valid_d;
  logic [7:0]  byte_q;
  logic        adv;
  logic        in_acc;

  logic        in_payload_q, in_payload_d;
  logic [1:0]  hdr_cnt_q, hdr_cnt_d;
  logic        start_ok_q, start_ok_d;
  logic [7:0]  len_high_q, len_high_d;
  logic [15:0] bytes_left_q, bytes_left_d;
  logic [7:0]  sum_q, sum_d;
  logic [16:0] byte_cnt_q, byte_cnt_d;

  logic [16:0] total;
  logic [7:0]  sum_add;
  logic [15:0] left_dec;
  logic        fend;
  frsc_pkg::status_e status;

  assign adv        = s1_valid_q & res_take_i;
  assign in_stall_o = s1_valid_q & ~res_take_i;
  assign in_acc     = in_valid_i & ~in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      byte_q <= rx_byte_i;
    end
  end

  // per-byte frame step
  assign total    = byte_cnt_q + 17'd1;
  assign sum_add  = sum_q + byte_q;
  assign left_dec = bytes_left_q - 16'd1;

  always_comb begin
    in_payload_d = in_payload_q;
    hdr_cnt_d    = hdr_cnt_q;
    start_ok_d   = start_ok_q;
    len_high_d   = len_high_q;
    bytes_left_d = bytes_left_q;
    sum_d        = sum_q;
    byte_cnt_d   = total;
    fend         = 1'b0;
    status       = frsc_pkg::STATUS_OK;

    if (in_payload_q) begin
      sum_d        = sum_add;
      bytes_left_d = left_dec;
      if (left_dec == 16'd0) begin
        fend   = 1'b1;
        status = (sum_add == 8'd0) ? frsc_pkg::STATUS_OK : frsc_pkg::STATUS_BAD_CSUM;
      end
    end else begin
      unique case (hdr_cnt_q)
        HDR_START: begin
          start_ok_d = (byte_q == frsc_pkg::START_BYTE);
          sum_d      = 8'd0;
          hdr_cnt_d  = HDR_LEN_HI;
        end
        HDR_LEN_HI: begin
          len_high_d = byte_q;
          sum_d      = byte_q;
          hdr_cnt_d  = HDR_LEN_LO;
        end
        HDR_LEN_LO: begin
          bytes_left_d = {len_high_q, byte_q};
          sum_d        = sum_add;
          hdr_cnt_d    = HDR_OPCODE;
        end
        default: begin
          sum_d = sum_add;
          priority if (!start_ok_q) begin
            fend   = 1'b1;
            status = frsc_pkg::STATUS_BAD_START;
          end else if (bytes_left_q > max_payload_i) begin
            fend   = 1'b1;
            status = frsc_pkg::STATUS_TOO_LONG;
          end else if (bytes_left_q == 16'd0) begin
            fend   = 1'b1;
            status = (sum_add == 8'd0) ? frsc_pkg::STATUS_OK
                                       : frsc_pkg::STATUS_BAD_CSUM;
          end else begin
            in_payload_d = 1'b1;
            hdr_cnt_d    = HDR_START;
          end
        end
      endcase
    end

    // frame closed: back to header collection
    if (fend) begin
      in_payload_d = 1'b0;
      hdr_cnt_d    = HDR_START;
      sum_d        = 8'd0;
      byte_cnt_d   = 17'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_payload_q <= 1'b0;
      hdr_cnt_q    <= HDR_START;
      start_ok_q   <= 1'b0;
      len_high_q   <= 8'd0;
      bytes_left_q <= 16'd0;
      sum_q        <= 8'd0;
      byte_cnt_q   <= 17'd0;
    end else if (adv) begin
      in_payload_q <= in_payload_d;
      hdr_cnt_q    <= hdr_cnt_d;
      start_ok_q   <= start_ok_d;
      len_high_q   <= len_high_d;
      bytes_left_q <= bytes_left_d;
      sum_q        <= sum_d;
      byte_cnt_q   <= byte_cnt_d;
    end
  end

  assign res_valid_o        = s1_valid_q;
  assign res_o.byte_out     = byte_q;
  assign res_o.frame_end    = fend;
  assign res_o.frame_status = status;
  assign res_o.frame_total  = total;

  `FRSC_ASSERT_IMP(a_payload_hdr_idle, clk_i, rst_ni, in_payload_q, hdr_cnt_q == HDR_START,
    "header counter busy while in payload")
  `FRSC_ASSERT_NXT(a_end_clears_count, clk_i, rst_ni, adv && fend,
    byte_cnt_q == 17'd0 && sum_q == 8'd0, "frame end did not clear counters")
  `FRSC_ASSERT_IMP(a_discard_len, clk_i, rst_ni,
    adv && fend && (status == frsc_pkg::STATUS_BAD_START ||
                    status == frsc_pkg::STATUS_TOO_LONG),
    total == frsc_pkg::HEADER_LEN, "discarded header not four bytes")
  `FRSC_ASSERT_IMP(a_no_early_end, clk_i, rst_ni,
    !in_payload_q && hdr_cnt_q != HDR_OPCODE, !fend, "frame end inside header")

endmodule

@@ rtl/core/frsc_out_reg.sv @@
// ----------------------------------------------------------------------------
// frsc_out_reg
// result register between the parser and the output channel
// ----------------------------------------------------------------------------
module frsc_out_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           res_valid_i,
  output logic           res_take_o,
  input  frsc_pkg::res_t res_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output frsc_pkg::res_t out_o
);

  logic           out_valid_q, out_valid_d;
  frsc_pkg::res_t res_q;

  // register may load when empty or being drained this cycle
  assign res_take_o = ~out_valid_q | ~out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_take_o) begin
      out_valid_d = res_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = res_q;

endmodule

@@ rtl/core/frame_receiver_sum_checksum_unit.sv @@
// ----------------------------------------------------------------------------
// frame_receiver_sum_checksum_unit
// length-prefixed serial frame parser with two's-complement sum checksum
// ----------------------------------------------------------------------------
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+--------------------------------
//  in       | input     | in_valid_i/in_stall_o  | rx_byte_i
//  out      | output    | out_valid_o/out_stall_i| byte_out_o, frame_end_o,
//           |           |                        | frame_status_o, frame_total_o
//  cfg      | input     | max_payload_we_i       | max_payload_i
//
// one result beat per input beat, one beat per cycle sustained while the output is not stalled
// each beat passes through the input register, then the result register
// the parse step (8-bit sum, 16-bit length compare, 17-bit count) sits between them
// a stalled output only holds the input side once both registers are full
// asynchronous active-low reset clears all frame state and loads max_payload 256
// ----------------------------------------------------------------------------
module frame_receiver_sum_checksum_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input byte channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  byte_out_o,
  output logic        frame_end_o,
  output logic [1:0]  frame_status_o,
  output logic [16:0] frame_total_o,
  // configuration
  input  logic        max_payload_we_i,
  input  logic [15:0] max_payload_i
);

  // largest length accepted; longer frames are dropped after their header
  logic [15:0]    max_payload_q;

  // parser to result register
  logic           res_valid;
  logic           res_take;
  frsc_pkg::res_t res;
  frsc_pkg::res_t out_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= frsc_pkg::MAX_PAYLOAD_RST;
    end else if (max_payload_we_i) begin
      max_payload_q <= max_payload_i;
    end
  end

  // input register plus header/payload tracking
  frsc_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .rx_byte_i     (rx_byte_i),
    .max_payload_i (max_payload_q),
    .res_valid_o   (res_valid),
    .res_take_i    (res_take),
    .res_o         (res)
  );

  // result register, decouples the output stall from the parse step
  frsc_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_take_o  (res_take),
    .res_i       (res),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_res)
  );

  // status code is zero unless the beat closes a frame
  assign byte_out_o     = out_res.byte_out;
  assign frame_end_o    = out_res.frame_end;
  assign frame_status_o = out_res.frame_status;
  assign frame_total_o  = out_res.frame_total;

endmodule

@@ sim/frame_receiver_sum_checksum_unit_checker.sv @@
// ----------------------------------------------------------------------------
// frame receiver result checker
// watches the byte, result and register ports, tracks the frame parse on its
// own and compares every result beat with the oldest outstanding prediction
// ----------------------------------------------------------------------------
module frame_receiver_sum_checksum_unit_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [7:0]  byte_out_i,
  input  logic        frame_end_i,
  input  logic [1:0]  frame_status_i,
  input  logic [16:0] frame_total_i,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_data_i,
  output int          errors_o,
  output int          pending_o
);

  // header byte positions
  localparam logic [1:0] HDR_START  = 2'd0;
  localparam logic [1:0] HDR_LEN_HI = 2'd1;
  localparam logic [1:0] HDR_LEN_LO = 2'd2;
  localparam logic [1:0] HDR_OPCODE = 2'd3;

  // parse state
  logic        in_body;
  logic [1:0]  hdr_pos;
  logic        start_seen;
  logic [7:0]  len_hi;
  logic [15:0] remaining;
  logic [7:0]  csum_acc;
  logic [16:0] frame_len;
  logic [15:0] max_len;

  frsc_pkg::res_t beats_q[$];
  frsc_pkg::res_t beat;
  frsc_pkg::res_t want;
  int             errors;

  task automatic parse_byte(input logic [7:0] b, output frsc_pkg::res_t r);
    logic              done_frame;
    frsc_pkg::status_e st;
    done_frame = 1'b0;
    st         = frsc_pkg::STATUS_OK;
    frame_len  = frame_len + 17'd1;
    if (in_body) begin
      csum_acc  = csum_acc + b;
      remaining = remaining - 16'd1;
      if (remaining == 16'd0) begin
        done_frame = 1'b1;
        st         = (csum_acc == 8'd0) ? frsc_pkg::STATUS_OK : frsc_pkg::STATUS_BAD_CSUM;
      end
    end else begin
      case (hdr_pos)
        HDR_START: begin
          start_seen = (b == frsc_pkg::START_BYTE);
          csum_acc   = 8'd0;
          hdr_pos    = HDR_LEN_HI;
        end
        HDR_LEN_HI: begin
          len_hi   = b;
          csum_acc = b;
          hdr_pos  = HDR_LEN_LO;
        end
        HDR_LEN_LO: begin
          remaining = {len_hi, b};
          csum_acc  = csum_acc + b;
          hdr_pos   = HDR_OPCODE;
        end
        default: begin
          csum_acc = csum_acc + b;
          // bad start wins over too long
          if (!start_seen) begin
            done_frame = 1'b1;
            st         = frsc_pkg::STATUS_BAD_START;
          end else if (remaining > max_len) begin
            done_frame = 1'b1;
            st         = frsc_pkg::STATUS_TOO_LONG;
          end else if (remaining == 16'd0) begin
            done_frame = 1'b1;
            st         = (csum_acc == 8'd0) ? frsc_pkg::STATUS_OK
                                            : frsc_pkg::STATUS_BAD_CSUM;
          end else begin
            in_body = 1'b1;
            hdr_pos = HDR_START;
          end
        end
      endcase
    end
    r.byte_out     = b;
    r.frame_end    = done_frame;
    r.frame_status = st;
    r.frame_total  = frame_len;
    if (done_frame) begin
      in_body   = 1'b0;
      hdr_pos   = HDR_START;
      csum_acc  = 8'd0;
      frame_len = 17'd0;
    end
  endtask

  task automatic check_field(input string label, input logic [16:0] exp_v,
                             input logic [16:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, label, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_body    = 1'b0;
      hdr_pos    = HDR_START;
      start_seen = 1'b0;
      len_hi     = 8'd0;
      remaining  = 16'd0;
      csum_acc   = 8'd0;
      frame_len  = 17'd0;
      max_len    = frsc_pkg::MAX_PAYLOAD_RST;
      errors     = 0;
      beats_q.delete();
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        max_len = cfg_data_i;
      end
      if (in_valid_i && !in_stall_i) begin
        parse_byte(rx_byte_i, beat);
        beats_q.push_back(beat);
      end
      if (out_valid_i && !out_stall_i) begin
        if (beats_q.size() == 0) begin
          $display("%0t: result beat with byte 0x%0h arrived with nothing outstanding",
                   $time, byte_out_i);
          errors++;
        end else begin
          want = beats_q.pop_front();
          check_field("byte_out", want.byte_out, byte_out_i);
          check_field("frame_end", want.frame_end, frame_end_i);
          check_field("frame_status", want.frame_status, frame_status_i);
          check_field("frame_total", want.frame_total, frame_total_i);
        end
      end
      errors_o  <= errors;
      pending_o <= beats_q.size();
    end
  end

endmodule

@@ sim/frame_receiver_sum_checksum_unit_test.sv @@
// ----------------------------------------------------------------------------
// frame receiver testbench
// feeds framed byte streams (good, bad checksum, bad start, too long, raw
// noise) through the parser under several max_payload settings, with random
// gaps on the byte side and random stalls on the result side; the checker
// beside the block predicts and compares every result beat
// ----------------------------------------------------------------------------
module frame_receiver_sum_checksum_unit_test;

  localparam int CLK_PERIOD   = 12;
  localparam int RANDOM_BYTES = 650;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  byte_out;
  logic        frame_end;
  logic [1:0]  frame_status;
  logic [16:0] frame_total;
  logic        max_we;
  logic [15:0] max_val;
  int          errors;
  int          pending;

  // stimulus-side view of the limit, only used to shape frames
  int cur_max;
  int sent_bytes;
  int in_quiet;
  // both sides run flat out while set (long frame)
  bit rush;

  always begin
    #(CLK_PERIOD / 2) clk_i = 1'b1;
    #(CLK_PERIOD / 2) clk_i = 1'b0;
  end

  frame_receiver_sum_checksum_unit u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .rx_byte_i        (rx_byte),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .byte_out_o       (byte_out),
    .frame_end_o      (frame_end),
    .frame_status_o   (frame_status),
    .frame_total_o    (frame_total),
    .max_payload_we_i (max_we),
    .max_payload_i    (max_val)
  );

  frame_receiver_sum_checksum_unit_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .rx_byte_i      (rx_byte),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .byte_out_i     (byte_out),
    .frame_end_i    (frame_end),
    .frame_status_i (frame_status),
    .frame_total_i  (frame_total),
    .cfg_we_i       (max_we),
    .cfg_data_i     (max_val),
    .errors_o       (errors),
    .pending_o      (pending)
  );

  // one input beat: random gap first, then hold until taken
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (rush) begin
      gap = 0;
    end else if (in_quiet > 0) begin
      gap = 0;
      in_quiet--;
    end else begin
      gap = $urandom_range(0, 12);
      // now and then a run of back-to-back beats
      if ($urandom_range(0, 39) == 0) in_quiet = $urandom_range(8, 40);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk_i); while (in_stall);
    sent_bytes++;
  endtask

  // drop valid and wait for every outstanding result, plus the pipe depth
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (8) @(posedge clk_i);
  endtask

  // only called with the block drained
  task automatic write_max(input logic [15:0] v);
    max_we  <= 1'b1;
    max_val <= v;
    cur_max  = v;
    @(posedge clk_i);
    max_we  <= 1'b0;
  endtask

  // header, then the body only where the parser will take one; the last body
  // byte (or the opcode for a zero length) is the negated running sum, flipped when corrupt
  task automatic send_frame(input logic [7:0] sb, input int len, input bit corrupt);
    logic [15:0] l;
    logic [7:0]  acc;
    logic [7:0]  op;
    logic [7:0]  d;
    l   = len[15:0];
    acc = l[15:8] + l[7:0];
    send_byte(sb);
    send_byte(l[15:8]);
    send_byte(l[7:0]);
    if (l == 16'd0) begin
      op = -acc;
      if (corrupt) op = op ^ 8'($urandom_range(1, 255));
    end else begin
      op = 8'($urandom);
    end
    send_byte(op);
    if (sb == frsc_pkg::START_BYTE && l != 16'd0 && len <= cur_max) begin
      acc = acc + op;
      for (int i = 1; i < len; i++) begin
        d   = 8'($urandom);
        acc = acc + d;
        send_byte(d);
      end
      d = -acc;
      if (corrupt) d = d ^ 8'($urandom_range(1, 255));
      send_byte(d);
    end
  endtask

  // mostly short bodies, sometimes the full allowed length (capped at 300)
  function automatic int body_len();
    int cap;
    cap = (cur_max > 300) ? 300 : cur_max;
    case ($urandom_range(0, 9))
      0:       return cap;
      1:       return $urandom_range(0, cap);
      default: return $urandom_range(0, (cap > 12) ? 12 : cap);
    endcase
  endfunction

  task automatic random_frame();
    int         pick;
    logic [7:0] sb;
    pick = $urandom_range(0, 99);
    sb   = 8'($urandom);
    if (sb == frsc_pkg::START_BYTE) sb = 8'h55;
    if (cur_max == 0 && pick < 40) begin
      // raw noise: with a zero limit every header is exactly four beats,
      // so any four bytes keep the parser aligned
      send_byte($urandom_range(0, 1) ? frsc_pkg::START_BYTE : 8'($urandom));
      repeat (3) send_byte(8'($urandom));
    end else if (pick < 70) begin
      send_frame(frsc_pkg::START_BYTE, body_len(), 1'b0);
    end else if (pick < 82) begin
      send_frame(frsc_pkg::START_BYTE, body_len(), 1'b1);
    end else if (pick < 91 || cur_max == 65535) begin
      send_frame(sb, $urandom_range(0, 65535), 1'($urandom));
    end else if ($urandom_range(0, 3) == 0) begin
      // just over the limit
      send_frame(frsc_pkg::START_BYTE, cur_max + 1, 1'b0);
    end else begin
      send_frame(frsc_pkg::START_BYTE, $urandom_range(cur_max + 1, 65535), 1'b0);
    end
  endtask

  // result side: random stall before each beat, with quiet stretches
  initial begin : result_side
    int w;
    int quiet;
    out_stall = 1'b0;
    quiet     = 0;
    wait (rst_ni === 1'b1);
    forever begin
      if (rush) begin
        w = 0;
      end else if (quiet > 0) begin
        w = 0;
        quiet--;
      end else begin
        w = $urandom_range(0, 12);
        if ($urandom_range(0, 39) == 0) quiet = $urandom_range(8, 40);
      end
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(posedge clk_i);
        out_stall <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid);
    end
  end

  initial begin : stimulus
    int first;
    rst_ni     = 1'b0;
    in_valid   = 1'b0;
    rx_byte    = 8'd0;
    max_we     = 1'b0;
    max_val    = 16'd0;
    cur_max    = frsc_pkg::MAX_PAYLOAD_RST;
    sent_bytes = 0;
    in_quiet   = 0;
    rush       = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset limit of 256
    send_frame(frsc_pkg::START_BYTE, 0, 1'b0);    // zero length, good
    send_frame(frsc_pkg::START_BYTE, 0, 1'b1);    // zero length, bad checksum
    send_frame(8'h00, 5, 1'b0);                   // bad start
    send_frame(8'hFF, 65535, 1'b0);               // bad start over a too-long length
    send_frame(frsc_pkg::START_BYTE, 257, 1'b0);  // one over the limit
    send_frame(frsc_pkg::START_BYTE, 1, 1'b0);    // checksum only body
    send_frame(frsc_pkg::START_BYTE, 3, 1'b1);    // body with bad checksum

    // zero limit: anything with a body is too long
    settle();
    write_max(16'd0);
    send_frame(frsc_pkg::START_BYTE, 0, 1'b0);
    send_frame(frsc_pkg::START_BYTE, 1, 1'b0);

    // full limit with a frame well past 255 bytes, sum spans every byte
    settle();
    write_max(16'hFFFF);
    rush = 1'b1;
    send_frame(frsc_pkg::START_BYTE, 600, 1'b0);
    rush = 1'b0;

    // random phases, each under its own limit
    first = sent_bytes;
    while (sent_bytes - first < RANDOM_BYTES) begin
      settle();
      case ($urandom_range(0, 4))
        0:       write_max(16'd0);
        1:       write_max(16'hFFFF);
        2:       write_max(16'($urandom_range(1, 40)));
        3:       write_max(frsc_pkg::MAX_PAYLOAD_RST);
        default: write_max(16'($urandom));
      endcase
      repeat ($urandom_range(6, 24)) random_frame();
    end

    settle();
    if (errors == 0) begin
      $display("frame_receiver_sum_checksum_unit_test: done, clean");
    end else begin
      $display("frame_receiver_sum_checksum_unit_test: done, errors");
    end
    $finish;
  end

  // hang guard
  initial begin : watchdog
    #(CLK_PERIOD * 1000000);
    $display("frame_receiver_sum_checksum_unit_test: done, errors");
    $finish;
  end

endmodule
